FILE: src/tdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared types and codes of the tap dance key resolver.
// ----------------------------------------------------------------------------
package tdr_pkg;

    localparam logic [2:0] OP_PRESS   = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_SCAN    = 3'd2;
    localparam logic [2:0] OP_INTR    = 3'd3;
    localparam logic [2:0] OP_WRITE   = 3'd4;

    localparam logic [2:0] SL_TAP     = 3'd0;
    localparam logic [2:0] SL_HOLD    = 3'd1;
    localparam logic [2:0] SL_DOUBLE  = 3'd2;
    localparam logic [2:0] SL_TAPHOLD = 3'd3;
    localparam logic [2:0] SL_TERM    = 3'd4;
    localparam int         SLOTS      = 5;

    localparam logic [2:0] PH_NONE        = 3'd0;
    localparam logic [2:0] PH_SINGLE_TAP  = 3'd1;
    localparam logic [2:0] PH_SINGLE_HOLD = 3'd2;
    localparam logic [2:0] PH_DOUBLE_TAP  = 3'd3;
    localparam logic [2:0] PH_DOUBLE_HOLD = 3'd4;
    localparam logic [2:0] PH_INTERRUPTED = 3'd5;

    localparam logic [15:0] DEFAULT_TERM_RST = 16'd200;

    // per-entry dance state as stored in memory
    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  count;
        logic [15:0] ptime;
        logic        held;
        logic        fin;
    } t_dance;

    // one row of the action table: tap, hold, double, tap-hold, term
    typedef logic [SLOTS-1:0][15:0] t_row;

    typedef struct packed {
        logic        vld;
        logic [15:0] kc;
        logic        rel;
    } t_event;

endpackage

FILE: src/tap_dance_key_resolver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_dance_key_resolver
// Timing-based resolution of multi-function keys into key press/release beats.
// ----------------------------------------------------------------------------
// Sequence: a press/release/write item passes the accept, read, execute,
// emit and finish states, and emit stays until its event beats are staged.
// Scan and interrupt items walk every entry, each through read, execute and
// emit; each entry is a read-modify-write over the state memory. Output
// stalls hold the emit and finish states. The last beat of an item is
// presented the cycle after the finish state pushes it. One item at a time.
// Reset (synchronous, active low) clears the per-entry valid bits, so state
// and table read as zero at once; no clearing pass. default_term_ms is 200.
// ----------------------------------------------------------------------------
module tap_dance_key_resolver
    import tdr_pkg::*;
#(
    parameter int ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], entry_index[10:3], now_ms[26:11], table_slot[29:27],
    // table_value[45:30], zero fill [47:46]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // keycode[15:0]
    output logic [15:0] m_axis_tdata,
    // key_release[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DW = $bits(t_dance);
    localparam int RW = $bits(t_row);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EX   = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [15:0]  r_def_term;
    logic [2:0]   r_op;
    logic [15:0]  r_now;
    logic [2:0]   r_slot;
    logic [15:0]  r_val;
    logic         r_single;
    logic [IW-1:0] r_idx, n_idx;
    logic [ENTRIES-1:0] r_st_vld, r_tb_vld;
    t_event       r_ev0, r_ev1, r_pend, n_ev0, n_ev1, n_pend;
    logic         r_ov, n_ov;
    t_event       r_out, n_out;

    logic [DW-1:0] st_rdata;
    logic [RW-1:0] tb_rdata;
    t_dance        cur, nxt;
    t_row          row, row_w;
    logic          st_we, tb_we;
    t_event        e0, e1;

    // input field decode
    logic [2:0]  in_op;
    logic [7:0]  in_ent;
    logic        in_ok;
    assign in_op  = s_axis_tdata[2:0];
    assign in_ent = s_axis_tdata[10:3];
    assign in_ok  = {1'b0, in_ent} < 9'(ENTRIES);

    tdr_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_idx),
        .i_wdata (nxt),
        .i_raddr (r_idx),
        .o_rdata (st_rdata)
    );

    tdr_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (tb_we),
        .i_waddr (r_idx),
        .i_wdata (row_w),
        .i_raddr (r_idx),
        .o_rdata (tb_rdata)
    );

    assign st_we = (r_state == S_EX) && (r_op != OP_WRITE);
    assign tb_we = (r_state == S_EX) && (r_op == OP_WRITE) && (r_slot <= SL_TERM);

    // resolve one entry from the read data
    always_comb begin
        logic [15:0] k_tap, k_hold, k_dbl, k_th, k_set, term, elapsed;
        logic        settled;
        cur = r_st_vld[r_idx] ? t_dance'(st_rdata) : '0;
        row = r_tb_vld[r_idx] ? t_row'(tb_rdata) : '0;
        k_tap   = row[SL_TAP];
        k_hold  = (row[SL_HOLD] != 16'd0) ? row[SL_HOLD] : k_tap;
        k_dbl   = (row[SL_DOUBLE] != 16'd0) ? row[SL_DOUBLE] : k_tap;
        k_th    = (row[SL_TAPHOLD] != 16'd0) ? row[SL_TAPHOLD] : k_dbl;
        term    = (row[SL_TERM] != 16'd0) ? row[SL_TERM] : r_def_term;
        elapsed = r_now - cur.ptime;
        case (cur.phase)
            PH_SINGLE_HOLD: k_set = k_hold;
            PH_DOUBLE_TAP:  k_set = k_dbl;
            PH_DOUBLE_HOLD: k_set = k_th;
            default:        k_set = k_tap;
        endcase
        settled = 1'b0;
        nxt = cur;
        e0  = '0;
        e1  = '0;
        row_w = row;
        for (int s = 0; s < SLOTS; s++) begin
            if (r_slot == 3'(s)) begin
                row_w[s] = r_val;
            end
        end
        case (r_op)
            OP_PRESS: begin
                if (cur.fin) begin
                    nxt.held = 1'b0;
                    if (cur.phase != PH_NONE) begin
                        e0 = '{vld: 1'b1, kc: k_set, rel: 1'b1};
                        nxt = '0;
                        settled = 1'b1;
                    end
                end
                nxt.held  = 1'b1;
                nxt.count = nxt.count + 2'd1;
                nxt.ptime = r_now;
                if (nxt.count == 2'd3) begin
                    if (!settled) begin
                        e0 = '{vld: 1'b1, kc: k_tap, rel: 1'b0};
                    end
                    e1 = '{vld: 1'b1, kc: k_tap, rel: 1'b1};
                    nxt = '0;
                    nxt.held = 1'b1;
                end
            end
            OP_RELEASE: begin
                nxt.held = 1'b0;
                if (cur.fin && cur.phase != PH_NONE) begin
                    e0 = '{vld: 1'b1, kc: k_set, rel: 1'b1};
                    nxt = '0;
                end
            end
            OP_SCAN: begin
                if (cur.count != 2'd0 && !cur.fin && elapsed >= term) begin
                    nxt.fin = 1'b1;
                    if (!cur.held) begin
                        if (cur.count == 2'd1) begin
                            e0 = '{vld: 1'b1, kc: k_tap, rel: 1'b0};
                            e1 = '{vld: 1'b1, kc: k_tap, rel: 1'b1};
                        end else if (cur.count == 2'd2) begin
                            e0 = '{vld: 1'b1, kc: k_dbl, rel: 1'b0};
                            e1 = '{vld: 1'b1, kc: k_dbl, rel: 1'b1};
                        end
                        nxt = '0;
                    end else if (cur.count == 2'd1) begin
                        nxt.phase = PH_SINGLE_HOLD;
                        e0 = '{vld: 1'b1, kc: k_hold, rel: 1'b0};
                    end else if (cur.count == 2'd2) begin
                        nxt.phase = PH_DOUBLE_HOLD;
                        e0 = '{vld: 1'b1, kc: k_th, rel: 1'b0};
                    end
                end
            end
            OP_INTR: begin
                if (cur.count != 2'd0 && !cur.fin && cur.held) begin
                    nxt.phase = PH_INTERRUPTED;
                    nxt.fin   = 1'b1;
                    e0 = '{vld: 1'b1, kc: k_tap, rel: 1'b0};
                end
            end
            default: begin
            end
        endcase
        // drop events for empty keycodes
        e0.vld = e0.vld && (e0.kc != 16'd0);
        e1.vld = e1.vld && (e1.kc != 16'd0);
    end

    // sequencer and event staging
    always_comb begin
        logic out_free;
        out_free = !r_ov || m_axis_tready;
        n_state = r_state;
        n_idx   = r_idx;
        n_ev0   = r_ev0;
        n_ev1   = r_ev1;
        n_pend  = r_pend;
        n_ov    = r_ov && !m_axis_tready;
        n_out   = r_out;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if ((in_op == OP_PRESS || in_op == OP_RELEASE || in_op == OP_WRITE)
                            && in_ok) begin
                        n_idx   = in_ent[IW-1:0];
                        n_state = S_RD;
                    end else if (in_op == OP_SCAN || in_op == OP_INTR) begin
                        n_idx   = '0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_EX;
            S_EX: begin
                n_ev0   = e0;
                n_ev1   = e1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_ev0.vld || r_ev1.vld) begin
                    if (!r_pend.vld || out_free) begin
                        if (r_pend.vld) begin
                            n_out = r_pend;
                            n_ov  = 1'b1;
                        end
                        if (r_ev0.vld) begin
                            n_pend = r_ev0;
                            n_ev0.vld = 1'b0;
                        end else begin
                            n_pend = r_ev1;
                            n_ev1.vld = 1'b0;
                        end
                    end
                end else if (r_single || r_idx == IW'(ENTRIES - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_RD;
                end
            end
            S_FIN: begin
                if (!r_pend.vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out = r_pend;
                    n_ov  = 1'b1;
                    n_pend.vld = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // last flag rides on the beat pushed from the final stage
    logic r_olast, n_olast;
    always_comb begin
        n_olast = r_olast;
        if (r_state == S_EMIT && n_ov && (!r_ov || m_axis_tready)) begin
            n_olast = 1'b0;
        end
        if (r_state == S_FIN && r_pend.vld && (!r_ov || m_axis_tready)) begin
            n_olast = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_def_term <= DEFAULT_TERM_RST;
            r_st_vld   <= '0;
            r_tb_vld   <= '0;
            r_ov       <= 1'b0;
            r_pend.vld <= 1'b0;
            r_ev0.vld  <= 1'b0;
            r_ev1.vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_pend  <= n_pend;
            r_ev0   <= n_ev0;
            r_ev1   <= n_ev1;
            if (i_cfg_we) begin
                r_def_term <= i_cfg_wdata;
            end
            if (st_we) begin
                r_st_vld[r_idx] <= 1'b1;
            end
            if (tb_we) begin
                r_tb_vld[r_idx] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_out   <= n_out;
        r_olast <= n_olast;
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_op     <= in_op;
            r_now    <= s_axis_tdata[26:11];
            r_slot   <= s_axis_tdata[29:27];
            r_val    <= s_axis_tdata[45:30];
            r_single <= (in_op != OP_SCAN) && (in_op != OP_INTR);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out.kc;
    assign m_axis_tuser  = r_out.rel;
    assign m_axis_tlast  = r_olast;

    // checks
    a_kc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata != 16'd0)
        else $error("zero keycode beat");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(st_we && tb_we))
        else $error("state and table written together");
    a_ex_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX) |=> (r_state == S_EMIT))
        else $error("execute not followed by emit");

endmodule

FILE: src/tdr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
